// ===== rtl/mmac_pkg.sv =====
`default_nettype none

package mmac_pkg;

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 5;
  localparam int VAL_W  = 64;
  localparam int AB_W   = 32;
  localparam int C_W    = 64;
  localparam int FRAC_W = 16;
  localparam int SIZE_W = 6;

  localparam int                MAX_N_DEF  = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // Command codes carried on the input channel
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 3'd0,
    CMD_LOAD_B  = 3'd1,
    CMD_LOAD_C  = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_READ_C  = 3'd4
  } cmd_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  // Sequencer to MAC datapath controls
  typedef struct packed {
    logic clear;    // zero the accumulator
    logic prod_en;  // operands from the stores are valid, form the product
    logic acc_en;   // product register is valid, add it in
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mmac_if.sv =====
`default_nettype none

// Input channel: one command transaction
interface mmac_in_if;
  import mmac_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [VAL_W-1:0] value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

// Output channel: one C element read back
interface mmac_out_if;
  import mmac_pkg::*;

  logic           valid;
  logic           ready;
  logic [C_W-1:0] result_value;
  logic           in_range;

  modport source (output valid, result_value, in_range, input ready);
  modport sink   (input valid, result_value, in_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/mmac_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read
module mmac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/mmac_mac.sv =====
`default_nettype none

// Multiply-accumulate datapath: 32x32 signed product register, wide exact
// accumulator, then floor shift by 16 and saturating add onto the C element.
module mmac_mac #(
  parameter int MAX_N = mmac_pkg::MAX_N_DEF
) (
  input  wire logic                       clk_i,
  input  wire mmac_pkg::mac_ctl_t         ctl_i,
  input  wire logic [mmac_pkg::AB_W-1:0]  a_i,
  input  wire logic [mmac_pkg::AB_W-1:0]  b_i,
  input  wire logic [mmac_pkg::C_W-1:0]   c_i,
  output logic      [mmac_pkg::C_W-1:0]   c_o
);
  import mmac_pkg::*;

  localparam int PROD_W = 2 * AB_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_N);
  localparam int TOT_W  = ACC_W - FRAC_W;
  localparam int SUM_W  = C_W + 1;

  logic signed [AB_W-1:0]   a_s;
  logic signed [AB_W-1:0]   b_s;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [TOT_W-1:0]  total;
  logic signed [SUM_W-1:0]  sum;

  assign a_s = $signed(a_i);
  assign b_s = $signed(b_i);

  // 32x32 signed multiply on sign-extended operands
  assign prod_d = PROD_W'(a_s) * PROD_W'(b_s);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.acc_en) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // Exact sum of Q32.32 products, floor to Q37.16
  assign total = TOT_W'(acc_q >>> FRAC_W);
  assign sum   = $signed({c_i[C_W-1], c_i}) + SUM_W'(total);

  // Saturate to the signed 64-bit range
  always_comb begin
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      c_o = sum[SUM_W-1] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
    end else begin
      c_o = sum[C_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/matrix_multiply_accumulate.sv =====
`default_nettype none

// Square matrix multiply-accumulate, C := C + A*B, on n-by-n matrices.
// Input channel (in_ch): one transaction per command: load an element of A,
// B or C at (row, col), start the compute, or read back C(row, col).
// Output channel (out_ch): one transaction per read command, with the C value
// and a flag that says whether (row, col) lay inside n.
// Configuration: cfg_we_i writes matrix_size (n, clamped to MAX_N); write it
// only while the block is idle.
// Loads stream back to back. A read blocks the input in ST_READ while the C
// store is read; its result enters the output register at the end of
// ST_READ. A compute occupies the block until every C element is done: for
// each one the sequencer issues the n operand reads in ST_ISSUE (one read
// port per store, one multiplier), then drains the MAC pipeline and writes C
// back in ST_DRAIN.
// Reset clears the control state and sets matrix_size to 32; the A, B and C
// stores are not cleared and must be written before they are used.
// While a result waits in the output register, loads are still taken if the
// receiver takes it in the same cycle; otherwise input ready stays low until
// the output register is free.
module matrix_multiply_accumulate #(
  parameter int MAX_N = mmac_pkg::MAX_N_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mmac_pkg::SIZE_W-1:0] cfg_wdata_i,
  mmac_in_if.sink                          in_ch,
  mmac_out_if.source                       out_ch
);
  import mmac_pkg::*;

  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_N + 1);
  localparam int CW    = $clog2(MAX_N);

  state_e          state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [NW-1:0]   n;
  logic [CW-1:0]   r_q, r_d, c_q, c_d, k_q, k_d;
  logic            s1_q, s2_q;
  logic            rd_ok_q;
  logic            out_valid_q;
  logic [C_W-1:0]  out_value_q;
  logic            out_range_q;

  cmd_e            cmd;
  logic            in_acc;
  logic            in_ready;
  logic            ok;
  logic            k_last, c_last, r_last;
  logic            drain_done;
  logic [AW-1:0]   ld_addr, a_addr, b_addr, c_addr;
  logic [AW-1:0]   c_raddr, c_waddr;
  logic [C_W-1:0]  c_wdata, c_rdata, mac_c;
  logic [AB_W-1:0] a_rdata, b_rdata;
  logic            a_we, b_we, c_we;
  mac_ctl_t        mac_ctl;

  // Size register and the size in use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (int'(size_q) > MAX_N) begin
      n = NW'(MAX_N);
    end else begin
      n = NW'(size_q);
    end
  end

  // Command decode
  assign cmd     = cmd_e'(in_ch.cmd);
  assign in_acc  = in_ch.valid && in_ready;
  assign ok      = (int'(in_ch.row) < int'(n)) && (int'(in_ch.col) < int'(n));
  assign ld_addr = AW'(int'(in_ch.row) * MAX_N + int'(in_ch.col));

  // Compute addresses: A(r,k), B(k,c), C(r,c)
  assign a_addr = AW'(int'(r_q) * MAX_N + int'(k_q));
  assign b_addr = AW'(int'(k_q) * MAX_N + int'(c_q));
  assign c_addr = AW'(int'(r_q) * MAX_N + int'(c_q));

  assign k_last     = NW'(k_q) == (n - NW'(1));
  assign c_last     = NW'(c_q) == (n - NW'(1));
  assign r_last     = NW'(r_q) == (n - NW'(1));
  assign drain_done = (state_q == ST_DRAIN) && !s1_q && !s2_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd == CMD_READ_C) begin
            state_d = ST_READ;
          end else if (cmd == CMD_COMPUTE && n != '0) begin
            state_d = ST_ISSUE;
          end
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_ISSUE: begin
        if (k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_d = (c_last && r_last) ? ST_IDLE : ST_ISSUE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Loop counters over rows, columns and the inner index
  always_comb begin
    r_d = r_q;
    c_d = c_q;
    k_d = k_q;
    if (state_q == ST_IDLE) begin
      r_d = '0;
      c_d = '0;
      k_d = '0;
    end else if (state_q == ST_ISSUE) begin
      k_d = k_last ? '0 : k_q + CW'(1);
    end else if (drain_done) begin
      if (c_last) begin
        c_d = '0;
        r_d = r_q + CW'(1);
      end else begin
        c_d = c_q + CW'(1);
      end
    end
  end

  // Outputs of the sequencer: handshake, store ports, MAC controls
  always_comb begin
    in_ready        = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
    a_we            = (state_q == ST_IDLE) && in_acc && ok && (cmd == CMD_LOAD_A);
    b_we            = (state_q == ST_IDLE) && in_acc && ok && (cmd == CMD_LOAD_B);
    c_we            = drain_done ||
                      ((state_q == ST_IDLE) && in_acc && ok && (cmd == CMD_LOAD_C));
    c_raddr         = (state_q == ST_IDLE) ? ld_addr : c_addr;
    c_waddr         = (state_q == ST_IDLE) ? ld_addr : c_addr;
    c_wdata         = (state_q == ST_IDLE) ? in_ch.value : mac_c;
    mac_ctl.clear   = (state_q == ST_IDLE) || drain_done;
    mac_ctl.prod_en = s1_q;
    mac_ctl.acc_en  = s2_q;
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      s1_q    <= 1'b0;
      s2_q    <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      // operand read in flight, then product in flight
      s1_q    <= (state_q == ST_ISSUE);
      s2_q    <= s1_q;
      if (in_acc) begin
        rd_ok_q <= ok;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_READ) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      out_value_q <= rd_ok_q ? c_rdata : '0;
      out_range_q <= rd_ok_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.result_value = out_value_q;
  assign out_ch.in_range     = out_range_q;

  // Element stores
  mmac_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (ld_addr),
    .wdata_i (in_ch.value[AB_W-1:0]),
    .raddr_i (a_addr),
    .rdata_o (a_rdata)
  );

  mmac_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (ld_addr),
    .wdata_i (in_ch.value[AB_W-1:0]),
    .raddr_i (b_addr),
    .rdata_o (b_rdata)
  );

  mmac_ram #(.WIDTH(C_W), .DEPTH(DEPTH)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Multiply-accumulate datapath
  mmac_mac #(.MAX_N(MAX_N)) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (a_rdata),
    .b_i   (b_rdata),
    .c_i   (c_rdata),
    .c_o   (mac_c)
  );

endmodule

`default_nettype wire

// ===== rtl/mmac_checker.sv =====
`default_nettype none

// Port-level checks on the multiply-accumulate block
module mmac_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [mmac_pkg::CMD_W-1:0]  in_cmd,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [mmac_pkg::C_W-1:0]    out_value,
  input wire logic                        out_range
);
  import mmac_pkg::*;

  logic in_acc;
  logic rd_acc;

  assign in_acc = in_valid && in_ready;
  assign rd_acc = in_acc && (in_cmd == CMD_READ_C);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_range))
    else $error("result changed while stalled");

  // An out-of-range read returns zero
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_range |-> out_value == '0)
    else $error("out-of-range read returned nonzero value");

  // An accepted read command delivers a result
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |-> ##2 out_valid)
    else $error("read result missing");

  // Other commands give no result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_cmd != CMD_READ_C) && !out_valid |-> ##2 !out_valid)
    else $error("result without a read");

endmodule

bind matrix_multiply_accumulate mmac_checker u_mmac_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.result_value),
  .out_range (out_ch.in_range)
);

`default_nettype wire
